[hdl/pwns_pkg.sv]
// shared types, constants and widths of the perspective warp sampler
package pwns_pkg;

    // source image and map geometry
    localparam int SRC_WIDTH  = 512;
    localparam int SRC_HEIGHT = 512;
    localparam int MAP_WIDTH  = 1024;
    localparam int MAP_HEIGHT = 1024;

    // field widths
    localparam int COL_W  = $clog2(SRC_WIDTH);
    localparam int ROW_W  = $clog2(SRC_HEIGHT);
    localparam int PIX_W  = 8;
    localparam int X_W    = $clog2(MAP_WIDTH);
    localparam int Y_W    = $clog2(MAP_HEIGHT);
    localparam int ADDR_W = $clog2(SRC_WIDTH * SRC_HEIGHT);

    // request stream packing, lowest field first
    localparam int COL_LSB     = 0;
    localparam int ROW_LSB     = COL_LSB + COL_W;
    localparam int VAL_LSB     = ROW_LSB + ROW_W;
    localparam int X_LSB       = VAL_LSB + PIX_W;
    localparam int Y_LSB       = X_LSB + X_W;
    localparam int IN_FIELDS_W = Y_LSB + Y_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((PIX_W + 7) / 8) * 8;

    // coefficient registers
    localparam int COEF_W   = 48;
    localparam int NUM_COEF = 8;
    localparam int CIDX_W   = $clog2(NUM_COEF);

    localparam int REG_H00 = 0;
    localparam int REG_H01 = 1;
    localparam int REG_H02 = 2;
    localparam int REG_H10 = 3;
    localparam int REG_H11 = 4;
    localparam int REG_H12 = 5;
    localparam int REG_H20 = 6;
    localparam int REG_H21 = 7;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t ONE_Q24 = coef_t'(48'h0000_0100_0000);

    // arithmetic widths
    localparam int MAP_C_W = (X_W > Y_W) ? X_W : Y_W;
    localparam int PROD_W  = COEF_W + MAP_C_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int SRC_DIM = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int QB      = $clog2(SRC_DIM + 1);
    localparam int DIV_W   = SUM_W + QB;

    // pipeline depths
    localparam int XF_LAT  = 3;
    localparam int DIV_LAT = QB + 1;
    localparam int LAT     = XF_LAT + DIV_LAT;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [PIX_W-1:0] OUTSIDE_VALUE = PIX_W'(127);

    // request carried alongside the arithmetic
    typedef struct packed {
        logic              valid;
        logic              op;
        logic              wr_ok;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  value;
    } item_t;

    // signs and zero flag of the projected numerators and denominator
    typedef struct packed {
        logic u_neg;
        logic v_neg;
        logic w_neg;
        logic w_zero;
    } sign_t;

endpackage

[hdl/pwns_ram.sv]
// generic single-port synchronous ram with registered read
module pwns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one access per cycle, read data held while disabled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pwns_xform.sv]
// three-stage homography transform: products, sums, magnitudes and signs
module pwns_xform
    import pwns_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  coef_t            coef [NUM_COEF],
    input  logic [X_W-1:0]   x,
    input  logic [Y_W-1:0]   y,
    output logic [SUM_W-1:0] u_mag,
    output logic [SUM_W-1:0] v_mag,
    output logic [SUM_W-1:0] w_mag,
    output sign_t            sign
);

    logic signed [X_W:0]        xs;
    logic signed [Y_W:0]        ys;
    logic signed [PROD_W-1:0]   p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [SUM_W-1:0]    u_reg, v_reg, w_reg;
    logic [SUM_W-1:0]           u_mag_reg, v_mag_reg, w_mag_reg;
    sign_t                      sign_reg;

    assign xs = $signed({1'b0, x});
    assign ys = $signed({1'b0, y});

    // stage a: six coefficient by coordinate products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= PROD_W'(coef[REG_H00]) * PROD_W'(xs);
            p01_reg <= PROD_W'(coef[REG_H01]) * PROD_W'(ys);
            p10_reg <= PROD_W'(coef[REG_H10]) * PROD_W'(xs);
            p11_reg <= PROD_W'(coef[REG_H11]) * PROD_W'(ys);
            p20_reg <= PROD_W'(coef[REG_H20]) * PROD_W'(xs);
            p21_reg <= PROD_W'(coef[REG_H21]) * PROD_W'(ys);
        end
    end

    // stage b: numerators and denominator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= SUM_W'(p00_reg) + SUM_W'(p01_reg) + SUM_W'(coef[REG_H02]);
            v_reg <= SUM_W'(p10_reg) + SUM_W'(p11_reg) + SUM_W'(coef[REG_H12]);
            w_reg <= SUM_W'(p20_reg) + SUM_W'(p21_reg) + SUM_W'(ONE_Q24);
        end
    end

    // stage c: split into sign and magnitude for the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_mag_reg       <= u_reg[SUM_W-1] ? SUM_W'(-u_reg) : SUM_W'(u_reg);
            v_mag_reg       <= v_reg[SUM_W-1] ? SUM_W'(-v_reg) : SUM_W'(v_reg);
            w_mag_reg       <= w_reg[SUM_W-1] ? SUM_W'(-w_reg) : SUM_W'(w_reg);
            sign_reg.u_neg  <= u_reg[SUM_W-1];
            sign_reg.v_neg  <= v_reg[SUM_W-1];
            sign_reg.w_neg  <= w_reg[SUM_W-1];
            sign_reg.w_zero <= (w_reg == '0);
        end
    end

    assign u_mag = u_mag_reg;
    assign v_mag = v_mag_reg;
    assign w_mag = w_mag_reg;
    assign sign  = sign_reg;

endmodule

[hdl/pwns_div.sv]
// pipelined restoring divider, one quotient bit per stage, with range flag
module pwns_div
    import pwns_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [SUM_W-1:0] num,
    input  logic [SUM_W-1:0] den,
    output logic [QB-1:0]    quo,
    output logic             ovf
);

    logic [SUM_W-1:0] rem_reg [QB+1];
    logic [SUM_W-1:0] den_reg [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             ovf_reg [QB+1];

    // stage zero: flag quotients too large for the quotient bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= DIV_W'(num) >= (DIV_W'(den) << QB);
        end
    end

    // one trial subtract per stage, most significant bit first
    for (genvar s = 1; s <= QB; s++)
    begin : g_stage
        localparam int SH = QB - s;
        logic [DIV_W-1:0] trial;
        logic             ge;

        always_comb
        begin
            trial = DIV_W'(den_reg[s-1]) << SH;
            ge    = DIV_W'(rem_reg[s-1]) >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? SUM_W'(DIV_W'(rem_reg[s-1]) - trial) : rem_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                q_reg[s]   <= q_reg[s-1] | (QB'(ge) << SH);
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

[hdl/perspective_warp_nearest_sample_unit.sv]
// top level of the perspective warp nearest-neighbor sampler
//
// Requests enter on the s_ stream. tuser is the operation: a write stores
// src_value at (src_col, src_row) of the source image, a query projects
// (map_x, map_y) through the inverse homography and returns one result on
// the m_ stream: tdata is the sampled pixel, tuser is the inside flag
// (pixel 127 and flag clear when the point misses the image or w is zero).
// Writes return nothing. The user loads the eight coefficients through
// the cfg_ port while no request is in flight; the block does not enforce
// this. Throughput is one request per cycle while the output buffer has
// room. A query result passes three transform stages, eleven divider
// stages (one quotient bit each plus a range stage), the image ram read and
// the output register. Writes reach the ram at the same stage that queries
// read it, so every query sees exactly the writes accepted before it.
// Reset loads the identity transform and empties the pipeline; the image
// contents stay undefined until written, with no clearing pass.
// When the receiver stalls, a two-entry output buffer absorbs one more
// result and then drops s_tready, holding the whole pipeline in place.
module perspective_warp_nearest_sample_unit
    import pwns_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // src_col, src_row, src_value, map_x, map_y
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic                  s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // map_value
    output logic [OUT_DATA_W-1:0] m_tdata,
    // inside_res
    output logic                  m_tuser,
    // coefficient write port
    input  logic                  cfg_we,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]     cfg_data
);

    coef_t             coef_reg [NUM_COEF];
    item_t             side_reg [LAT];
    sign_t             sgn_reg  [DIV_LAT];
    item_t             item_in;
    item_t             tail;
    sign_t             tsg;
    logic              adv;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    logic [SUM_W-1:0]  u_mag, v_mag, w_mag;
    sign_t             xf_sign;
    logic [QB-1:0]     qc, qr;
    logic              ovfc, ovfr;
    logic              col_ok, row_ok, src_hit;
    logic              ram_en, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_rdata;
    logic              m_valid_reg, m_inside_reg;
    logic              push, pop;
    logic [PIX_W-1:0]  push_value;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_value_reg, out_value_next;
    logic              out_inside_reg, out_inside_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [PIX_W-1:0]  skid_value_reg, skid_value_next;
    logic              skid_inside_reg, skid_inside_next;

    // coefficient registers, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= (i == REG_H00 || i == REG_H11) ? ONE_Q24 : '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                if (cfg_we && cfg_index == CIDX_W'(i))
                begin
                    coef_reg[i] <= cfg_data;
                end
            end
        end
    end

    // the pipeline moves whenever the output buffer has room
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // request decode and write address
    assign in_col = s_tdata[COL_LSB +: COL_W];
    assign in_row = s_tdata[ROW_LSB +: ROW_W];

    always_comb
    begin
        item_in.valid = s_tvalid;
        item_in.op    = s_tuser;
        item_in.wr_ok = (int'(in_col) < SRC_WIDTH) && (int'(in_row) < SRC_HEIGHT);
        item_in.addr  = ADDR_W'(int'(in_row) * SRC_WIDTH + int'(in_col));
        item_in.value = s_tdata[VAL_LSB +: PIX_W];
    end

    // request line alongside the arithmetic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            side_reg[0] <= item_in;
            for (int i = 1; i < LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // sign line alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                sgn_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            sgn_reg[0] <= xf_sign;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sgn_reg[i] <= sgn_reg[i-1];
            end
        end
    end

    pwns_xform u_xform (
        .clk   (clk),
        .en    (adv),
        .coef  (coef_reg),
        .x     (s_tdata[X_LSB +: X_W]),
        .y     (s_tdata[Y_LSB +: Y_W]),
        .u_mag (u_mag),
        .v_mag (v_mag),
        .w_mag (w_mag),
        .sign  (xf_sign)
    );

    pwns_div u_div_col (
        .clk (clk),
        .en  (adv),
        .num (u_mag),
        .den (w_mag),
        .quo (qc),
        .ovf (ovfc)
    );

    pwns_div u_div_row (
        .clk (clk),
        .en  (adv),
        .num (v_mag),
        .den (w_mag),
        .quo (qr),
        .ovf (ovfr)
    );

    assign tail = side_reg[LAT-1];
    assign tsg  = sgn_reg[DIV_LAT-1];

    // inside test: a negative quotient is outside unless it truncates to zero
    always_comb
    begin
        col_ok  = !ovfc && (qc == '0 || tsg.u_neg == tsg.w_neg) && (int'(qc) < SRC_WIDTH);
        row_ok  = !ovfr && (qr == '0 || tsg.v_neg == tsg.w_neg) && (int'(qr) < SRC_HEIGHT);
        src_hit = !tsg.w_zero && col_ok && row_ok;
    end

    // image access: writes and query reads share the single port in order
    always_comb
    begin
        ram_en   = adv && tail.valid;
        ram_we   = (tail.op == OP_WRITE) && tail.wr_ok;
        ram_addr = (tail.op == OP_WRITE) ? tail.addr
                                         : ADDR_W'(int'(qr) * SRC_WIDTH + int'(qc));
    end

    pwns_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SRC_WIDTH * SRC_HEIGHT)
    ) u_image (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (tail.value),
        .rdata (ram_rdata)
    );

    // stage that waits for the ram read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg  <= 1'b0;
            m_inside_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg  <= tail.valid && (tail.op == OP_QUERY);
            m_inside_reg <= src_hit;
        end
    end

    assign push       = adv && m_valid_reg;
    assign push_value = m_inside_reg ? ram_rdata : OUTSIDE_VALUE;
    assign pop        = out_valid_reg && m_tready;

    // output register with one skid entry
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_inside_next  = out_inside_reg;
        skid_valid_next  = skid_valid_reg;
        skid_value_next  = skid_value_reg;
        skid_inside_next = skid_inside_reg;
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_next  = 1'b1;
                out_value_next  = skid_value_reg;
                out_inside_next = skid_inside_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_next  = push;
            out_value_next  = push_value;
            out_inside_next = m_inside_reg;
        end
        else if (push)
        begin
            skid_valid_next  = 1'b1;
            skid_value_next  = push_value;
            skid_inside_next = m_inside_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg   <= out_value_next;
        out_inside_reg  <= out_inside_next;
        skid_value_reg  <= skid_value_next;
        skid_inside_reg <= skid_inside_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_value_reg);
    assign m_tuser  = out_inside_reg;

    // skid entry is only used behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // a result arriving at a stalled output is kept in the skid entry
    a_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
        push && out_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("result dropped at stalled output");

    // a full buffer freezes the read stage and the end of the pipeline
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(m_valid_reg) && $stable(tail.valid))
        else $error("pipeline moved while output buffer full");

endmodule

[bench/tb.sv]
// testbench of the perspective warp nearest-neighbor sampler: streamed requests, scoreboard
`timescale 1ns / 100ps

module tb;
    import pwns_pkg::*;

    localparam int CLK_HALF          = 6;
    localparam int RESET_CYCLES      = 5;
    localparam int DRAIN_CYCLES      = 2 * (LAT + 4);
    localparam int HOLDOFF_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int MAX_REPORT_LINES  = 100;
    localparam int ITEMS_PER_SETTING = 130;
    localparam int NUM_IDLE_MODES    = 4;
    localparam int SEND_IDLE[NUM_IDLE_MODES] = '{0, 65, 0, 35};
    localparam int RECV_IDLE[NUM_IDLE_MODES] = '{0, 0, 65, 35};
    localparam int IMAGE_PIXELS      = SRC_WIDTH * SRC_HEIGHT;

    localparam longint Q24_ONE   = longint'(ONE_Q24);
    localparam longint COEF_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint COEF_MIN  = -64'sh0000_8000_0000_0000;

    // transform settings swept after the reset-value phase
    typedef enum int {
        SET_HALF, SET_AFFINE, SET_PERSP, SET_WZERO, SET_MAX, SET_MIN,
        SET_MIXED, SET_RANDOM, SET_OFFSET, NUM_SETTINGS
    } setting_e;

    typedef longint transform_t [NUM_COEF];

    typedef struct {
        logic                 op;
        logic [IN_DATA_W-1:0] data;
    } request_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             in_image;
    } sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CIDX_W-1:0]     cfg_index = '0;
    logic [COEF_W-1:0]     cfg_data = '0;

    // stimulus and prediction state
    request_t         pending_requests[$];
    sample_t          expected_samples[$];
    longint           coef_q24 [NUM_COEF] = '{Q24_ONE, 0, 0, 0, Q24_ONE, 0, 0, 0};
    logic [PIX_W-1:0] image_model [IMAGE_PIXELS];
    bit               pixel_planned [IMAGE_PIXELS];
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               holdoff_requests = 0;
    int               holdoff_served = 0;
    int               holdoff_left = 0;
    int               idle_cycles = 0;
    int               mismatch_count = 0;

    perspective_warp_nearest_sample_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORT_LINES)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // inverse homography, exact integer quotients truncated toward zero
    function automatic void project_to_source(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                              output logic hit, output int addr);
        longint xs;
        longint ys;
        longint u;
        longint v;
        longint w;
        longint sc;
        longint sr;
        xs = longint'(x);
        ys = longint'(y);
        u = coef_q24[REG_H00] * xs + coef_q24[REG_H01] * ys + coef_q24[REG_H02];
        v = coef_q24[REG_H10] * xs + coef_q24[REG_H11] * ys + coef_q24[REG_H12];
        w = coef_q24[REG_H20] * xs + coef_q24[REG_H21] * ys + Q24_ONE;
        hit = 1'b0;
        addr = 0;
        if (w != 0) begin
            sc = u / w;
            sr = v / w;
            if (sc >= 0 && sc < SRC_WIDTH && sr >= 0 && sr < SRC_HEIGHT) begin
                hit = 1'b1;
                addr = int'(sr) * SRC_WIDTH + int'(sc);
            end
        end
    endfunction

    // predictor: run at request acceptance
    function automatic void apply_request(input logic op, input logic [IN_DATA_W-1:0] d);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             hit;
        int               addr;
        sample_t          s;
        col = d[COL_LSB +: COL_W];
        row = d[ROW_LSB +: ROW_W];
        if (op == OP_WRITE) begin
            if (col < SRC_WIDTH && row < SRC_HEIGHT)
                image_model[int'(row) * SRC_WIDTH + int'(col)] = d[VAL_LSB +: PIX_W];
        end
        else begin
            project_to_source(d[X_LSB +: X_W], d[Y_LSB +: Y_W], hit, addr);
            s.value = hit ? image_model[addr] : OUTSIDE_VALUE;
            s.in_image = hit;
            expected_samples.push_back(s);
        end
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_fields(input int col, input int row,
                                                         input int val, input int x, input int y);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[COL_LSB +: COL_W] = COL_W'(col);
        d[ROW_LSB +: ROW_W] = ROW_W'(row);
        d[VAL_LSB +: PIX_W] = PIX_W'(val);
        d[X_LSB +: X_W]     = X_W'(x);
        d[Y_LSB +: Y_W]     = Y_W'(y);
        return d;
    endfunction

    // writes carry random map fields, queries random source fields
    function automatic void plan_write(input int col, input int row, input int val);
        request_t r;
        r.op = OP_WRITE;
        r.data = pack_fields(col, row, val, $urandom_range(MAP_WIDTH - 1),
                             $urandom_range(MAP_HEIGHT - 1));
        pending_requests.push_back(r);
        pixel_planned[row * SRC_WIDTH + col] = 1'b1;
    endfunction

    // a query that lands on an unwritten pixel gets a write first;
    // refresh rewrites the hit pixel right before the query
    function automatic void plan_query(input int x, input int y, input bit refresh);
        request_t r;
        logic     hit;
        int       addr;
        project_to_source(X_W'(x), Y_W'(y), hit, addr);
        if (hit && (refresh || !pixel_planned[addr]))
            plan_write(addr % SRC_WIDTH, addr / SRC_WIDTH, $urandom_range(255));
        r.op = OP_QUERY;
        r.data = pack_fields($urandom_range(SRC_WIDTH - 1), $urandom_range(SRC_HEIGHT - 1),
                             $urandom_range(255), x, y);
        pending_requests.push_back(r);
    endfunction

    // map coordinate biased toward zero, the image edge and the map edge
    function automatic int pick_map_coord();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return $urandom_range(15);
        if (r < 35)
            return $urandom_range(MAP_WIDTH - 1, MAP_WIDTH - 16);
        if (r < 50)
            return $urandom_range(SRC_WIDTH + 8, SRC_WIDTH - 8);
        return $urandom_range(MAP_WIDTH - 1);
    endfunction

    function automatic void plan_random_items(input int n);
        int target;
        int pick;
        target = pending_requests.size() + n;
        while (pending_requests.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 25)
                plan_write($urandom_range(SRC_WIDTH - 1), $urandom_range(SRC_HEIGHT - 1),
                           $urandom_range(255));
            else
                plan_query(pick_map_coord(), pick_map_coord(), pick < 40);
        end
    endfunction

    function automatic transform_t make_setting(input setting_e which);
        transform_t   t;
        logic [63:0]  raw;
        t = '{default: 0};
        case (which)
            SET_HALF: begin
                t[REG_H00] = Q24_ONE / 2;
                t[REG_H11] = Q24_ONE / 2;
            end
            SET_AFFINE: begin
                t[REG_H00] = 15099494;
                t[REG_H01] = -5033165;
                t[REG_H02] = 100 * Q24_ONE;
                t[REG_H10] = 5033165;
                t[REG_H11] = 15099494;
                t[REG_H12] = -50 * Q24_ONE;
            end
            SET_PERSP: begin
                t[REG_H00] = Q24_ONE;
                t[REG_H02] = 3 * Q24_ONE;
                t[REG_H11] = Q24_ONE;
                t[REG_H20] = 8389;
                t[REG_H21] = -4194;
            end
            SET_WZERO: begin
                // w = 1 - x/4 vanishes at x = 4 and is negative beyond
                t[REG_H00] = -Q24_ONE;
                t[REG_H11] = Q24_ONE;
                t[REG_H20] = -(Q24_ONE / 4);
            end
            SET_MAX: t = '{default: COEF_MAX};
            SET_MIN: t = '{default: COEF_MIN};
            SET_MIXED: begin
                t[REG_H00] = COEF_MAX;
                t[REG_H01] = COEF_MIN;
                t[REG_H10] = COEF_MIN;
                t[REG_H11] = COEF_MAX;
                t[REG_H12] = COEF_MAX;
                t[REG_H20] = COEF_MIN;
            end
            SET_RANDOM: begin
                foreach (t[i]) begin
                    raw = {$urandom(), $urandom()};
                    t[i] = longint'($signed(raw[COEF_W-1:0]));
                end
            end
            default: begin
                t[REG_H00] = Q24_ONE;
                t[REG_H01] = Q24_ONE / 8;
                t[REG_H02] = -100 * Q24_ONE;
                t[REG_H11] = Q24_ONE;
                t[REG_H12] = -300 * Q24_ONE;
            end
        endcase
        return t;
    endfunction

    // coefficient writes, only while nothing is in flight
    task automatic load_transform(input transform_t t);
        logic [63:0] raw;
        for (int i = 0; i < NUM_COEF; i++) begin
            raw = t[i];
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= CIDX_W'(i);
            cfg_data <= raw[COEF_W-1:0];
            coef_q24[i] = t[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender pause: hold until every result is back, then let writes settle
    task automatic wait_all_done();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int mode, input int items);
        send_idle_pct = SEND_IDLE[mode];
        recv_stall_pct = RECV_IDLE[mode];
        plan_random_items(items / 2);
        wait_all_done();
        plan_random_items(items - items / 2);
        wait_all_done();
    endtask

    // request driver
    always @(posedge clk) begin
        request_t next_req;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_req.op;
                    s_tdata <= next_req.data;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge clk) begin
        sample_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("result %0d/%0b with no query outstanding",
                                              m_tdata, m_tuser));
                else begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== OUT_DATA_W'(want.value))
                        report_mismatch($sformatf("map_value %0d, predicted %0d",
                                                  m_tdata, want.value));
                    if (m_tuser !== want.in_image)
                        report_mismatch($sformatf("inside flag %b, predicted %b",
                                                  m_tuser, want.in_image));
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end
            else if (holdoff_served != holdoff_requests) begin
                holdoff_served = holdoff_requests;
                holdoff_left = HOLDOFF_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no request and no result accepted
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("perspective_warp_nearest_sample_unit verification failed");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset identity transform, image corners, outside points, overwrite
        plan_write(0, 0, 8'h00);
        plan_write(SRC_WIDTH - 1, SRC_HEIGHT - 1, 8'hFF);
        plan_write(SRC_WIDTH - 1, 0, 8'hA5);
        plan_write(0, SRC_HEIGHT - 1, 8'h5A);
        plan_query(0, 0, 1'b0);
        plan_query(SRC_WIDTH - 1, SRC_HEIGHT - 1, 1'b0);
        plan_query(SRC_WIDTH - 1, 0, 1'b0);
        plan_query(0, SRC_HEIGHT - 1, 1'b0);
        plan_query(SRC_WIDTH, 0, 1'b0);
        plan_query(0, SRC_HEIGHT, 1'b0);
        plan_query(SRC_WIDTH, SRC_HEIGHT - 1, 1'b0);
        plan_query(MAP_WIDTH - 1, MAP_HEIGHT - 1, 1'b0);
        plan_write(5, 7, 8'h33);
        plan_query(5, 7, 1'b0);
        plan_write(5, 7, 8'hCC);
        plan_query(5, 7, 1'b0);
        wait_all_done();

        // receiver holds off while the sender keeps streaming
        holdoff_requests++;
        plan_random_items(80);
        wait_all_done();

        // transform sweep, idling mode rotating per setting
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            load_transform(make_setting(setting_e'(p)));
            if (setting_e'(p) == SET_WZERO) begin
                // zero denominator, and its neighbors on either sign of w
                plan_query(4, 0, 1'b0);
                plan_query(4, MAP_HEIGHT - 1, 1'b0);
                plan_query(3, 10, 1'b0);
                plan_query(5, 3, 1'b0);
            end
            run_phase(p % NUM_IDLE_MODES, ITEMS_PER_SETTING);
        end

        if (mismatch_count == 0)
            $display("perspective_warp_nearest_sample_unit verification clean");
        else
            $display("perspective_warp_nearest_sample_unit verification failed");
        $finish;
    end

endmodule
